>>> design/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg: shared definitions of the positional list engine
// Field widths, operation and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 6;
    localparam int COUNT_OUT_W  = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BEYOND = 2'd1,
        ST_BELOW  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // broadcast to every cell in the chain
    typedef struct packed {
        logic ins;
        logic del;
    } cell_ctrl_t;

endpackage

>>> design/ple_req_if.sv
// ----------------------------------------------------------------------------
// ple_req_if: request channel of the positional list engine
// Valid/ready channel carrying one list operation per beat.
// ----------------------------------------------------------------------------
interface ple_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 operation;
    logic signed [ple_pkg::POS_W-1:0]     position;
    logic signed [ple_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output operation, output position, output value,
                    input ready);
    modport sink   (input valid, input operation, input position, input value,
                    output ready);
endinterface

>>> design/ple_rsp_if.sv
// ----------------------------------------------------------------------------
// ple_rsp_if: response channel of the positional list engine
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface ple_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             status;
    logic signed [ple_pkg::VALUE_W-1:0]     removed_value;
    logic [ple_pkg::COUNT_OUT_W-1:0]        count_after;

    modport source (output valid, output status, output removed_value, output count_after,
                    input ready);
    modport sink   (input valid, input status, input removed_value, input count_after,
                    output ready);
endinterface

>>> design/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell: one slot of the list chain
// Holds one element; loads the new value, its left or its right neighbor.
// ----------------------------------------------------------------------------
module ple_cell #(
    parameter int IDX_W = 4,
    parameter int INDEX = 0
) (
    input  logic                           clk,
    input  ple_pkg::cell_ctrl_t            ctrl,
    input  logic [IDX_W-1:0]               slot,
    input  logic [ple_pkg::VALUE_W-1:0]    value,
    input  logic [ple_pkg::VALUE_W-1:0]    left_data,
    input  logic [ple_pkg::VALUE_W-1:0]    right_data,
    output logic [ple_pkg::VALUE_W-1:0]    data,
    output logic [ple_pkg::VALUE_W-1:0]    pick
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [ple_pkg::VALUE_W-1:0] data_reg;
    logic [ple_pkg::VALUE_W-1:0] data_next;
    logic                        load;
    logic                        hit;
    logic                        after;

    assign hit   = (slot == MY_IDX);
    assign after = (MY_IDX > slot);

    always_comb
    begin
        load      = 1'b0;
        data_next = data_reg;
        if (ctrl.ins)
        begin
            if (hit)
            begin
                load      = 1'b1;
                data_next = value;
            end
            else if (after)
            begin
                load      = 1'b1;
                data_next = left_data;
            end
        end
        else if (ctrl.del && (hit || after))
        begin
            // close the gap from the right
            load      = 1'b1;
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

    assign data = data_reg;
    assign pick = hit ? data_reg : '0;

endmodule

>>> design/positional_list_engine_core.sv
// ----------------------------------------------------------------------------
// positional_list_engine_core: ordered list with positional insert and delete
// The result is registered and is valid in the cycle after the request beat is accepted.
// Throughput: one operation per cycle while the response side keeps taking results; a waiting
// result still lets a new request in when the response side takes it in the same cycle.
// Reset clears the element count and the result valid; element slots are not
// cleared and are only read once written.
// ----------------------------------------------------------------------------
module positional_list_engine_core #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ple_req_if.sink     req,
    ple_rsp_if.source   rsp
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > ple_pkg::POS_W - 1) ? CNT_W : ple_pkg::POS_W - 1) + 1;
    localparam int VW    = ple_pkg::VALUE_W;

    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               count_next;
    logic                           rsp_valid_reg;
    ple_pkg::status_t               status_reg;
    ple_pkg::status_t               status_next;
    logic [VW-1:0]                  removed_reg;
    logic [VW-1:0]                  removed_next;

    logic                           accept;
    logic                           pos_neg;
    logic                           pos_minus1;
    logic [CMP_W-1:0]               pos_ext;
    logic [CMP_W-1:0]               cnt_ext;
    logic                           is_full;
    logic [IDX_W-1:0]               slot;
    ple_pkg::cell_ctrl_t            ctrl;
    logic [VW-1:0]                  cell_data [CAPACITY];
    logic [VW-1:0]                  cell_pick [CAPACITY];
    logic [VW-1:0]                  picked;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign pos_neg    = req.position[ple_pkg::POS_W-1];
    assign pos_minus1 = (req.position == -6'sd1);
    assign pos_ext    = CMP_W'(req.position[ple_pkg::POS_W-2:0]);
    assign cnt_ext    = CMP_W'(count_reg);
    assign is_full    = (cnt_ext == CMP_W'(CAPACITY));

    // decode and range checks
    always_comb
    begin
        status_next = ple_pkg::ST_OK;
        ctrl        = '0;
        slot        = IDX_W'(pos_ext);
        count_next  = count_reg;
        case (ple_pkg::op_t'(req.operation))
            ple_pkg::OP_INSERT:
            begin
                if (pos_neg && !pos_minus1)
                    status_next = ple_pkg::ST_BELOW;
                else if (!pos_neg && (pos_ext > cnt_ext))
                    status_next = ple_pkg::ST_BEYOND;
                else if (is_full)
                    status_next = ple_pkg::ST_FULL;
                else
                begin
                    if (pos_minus1)
                        slot = IDX_W'(count_reg);
                    ctrl.ins   = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            ple_pkg::OP_DELETE:
            begin
                if (pos_neg || (pos_ext == '0))
                    status_next = ple_pkg::ST_BELOW;
                else if (pos_ext > cnt_ext)
                    status_next = ple_pkg::ST_BEYOND;
                else
                begin
                    slot       = IDX_W'(pos_ext - 1'b1);
                    ctrl.del   = accept;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = ple_pkg::ST_OK;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [VW-1:0] left_in;
            logic [VW-1:0] right_in;
            if (gi == 0)
            begin : g_first
                assign left_in = cell_data[gi];
            end
            else
            begin : g_mid_l
                assign left_in = cell_data[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_in = cell_data[gi];
            end
            else
            begin : g_mid_r
                assign right_in = cell_data[gi+1];
            end
            ple_cell #(
                .IDX_W (IDX_W),
                .INDEX (gi)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .slot       (slot),
                .value      (req.value),
                .left_data  (left_in),
                .right_data (right_in),
                .data       (cell_data[gi]),
                .pick       (cell_pick[gi])
            );
        end
    endgenerate

    always_comb
    begin
        picked = '0;
        for (int i = 0; i < CAPACITY; i++)
            picked = picked | cell_pick[i];
    end

    assign removed_next = ctrl.del ? picked : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                count_reg <= count_next;
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.removed_value = removed_reg;
    assign rsp.count_after   = ple_pkg::COUNT_OUT_W'(count_reg);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("accepted request gave no result");

    a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.del |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("successful delete did not shrink the list");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("successful insert did not grow the list");
`endif

endmodule

>>> tb/ple_list_checker.sv
// ----------------------------------------------------------------------------
// ple_list_checker: result checker of the positional list engine
// Watches the request and response channels, keeps its own copy of the list,
// predicts the result of every accepted request and compares each accepted
// response with the oldest prediction.
// ----------------------------------------------------------------------------
module ple_list_checker #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    ple_req_if    req,
    ple_rsp_if    rsp,
    output int    fail_count,
    output int    pending
);

    localparam int VALUE_W     = ple_pkg::VALUE_W;
    localparam int POS_W       = ple_pkg::POS_W;
    localparam int COUNT_OUT_W = ple_pkg::COUNT_OUT_W;

    typedef struct {
        ple_pkg::status_t           status;
        logic signed [VALUE_W-1:0]  removed_value;
        logic [COUNT_OUT_W-1:0]     count_after;
    } list_result_t;

    logic signed [VALUE_W-1:0] shadow_slots [CAPACITY];
    int                        shadow_len;
    list_result_t              expected_results [$];

    // apply one operation to the shadow list and return what the block should say
    function automatic list_result_t apply_list_op(input logic op_bit,
                                                   input logic signed [POS_W-1:0] pos,
                                                   input logic signed [VALUE_W-1:0] val);
        list_result_t r;
        int           p;
        int           slot;
        p               = pos;
        r.status        = ple_pkg::ST_OK;
        r.removed_value = '0;
        if (ple_pkg::op_t'(op_bit) == ple_pkg::OP_INSERT)
        begin
            if (p < -1)
                r.status = ple_pkg::ST_BELOW;
            else if (p != -1 && p > shadow_len)
                r.status = ple_pkg::ST_BEYOND;
            else if (shadow_len >= CAPACITY)
                r.status = ple_pkg::ST_FULL;
            else
            begin
                slot = (p == -1) ? shadow_len : p;
                for (int i = shadow_len; i > slot; i--)
                    shadow_slots[i] = shadow_slots[i-1];
                shadow_slots[slot] = val;
                shadow_len++;
            end
        end
        else
        begin
            if (p < 1)
                r.status = ple_pkg::ST_BELOW;
            else if (p > shadow_len)
                r.status = ple_pkg::ST_BEYOND;
            else
            begin
                r.removed_value = shadow_slots[p-1];
                for (int i = p - 1; i + 1 < shadow_len; i++)
                    shadow_slots[i] = shadow_slots[i+1];
                shadow_len--;
            end
        end
        r.count_after = COUNT_OUT_W'(shadow_len);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        list_result_t exp_r;
        if (!rst_n)
        begin
            shadow_len = 0;
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            // the response at this edge belongs to an earlier request, check it first
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: response beat with nothing expected: status %0d removed %h count %0d",
                             $time, rsp.status, rsp.removed_value, rsp.count_after);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (rsp.status !== exp_r.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_r.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.removed_value !== exp_r.removed_value)
                    begin
                        $display("%0t: removed_value expected %h actual %h",
                                 $time, exp_r.removed_value, rsp.removed_value);
                        fail_count++;
                    end
                    if (rsp.count_after !== exp_r.count_after)
                    begin
                        $display("%0t: count_after expected %0d actual %0d",
                                 $time, exp_r.count_after, rsp.count_after);
                        fail_count++;
                    end
                end
            end
            if (req.valid && req.ready)
                expected_results.push_back(apply_list_op(req.operation, req.position,
                                                         req.value));
        end
        pending = expected_results.size();
    end

endmodule

>>> tb/positional_list_engine_core_tb.sv
// ----------------------------------------------------------------------------
// positional_list_engine_core_tb: testbench of the positional list engine
// Directed corner operations on an empty and a full list, then random insert
// and delete traffic that alternates between filling and draining, with
// random gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module positional_list_engine_core_tb;

    localparam int CAPACITY     = ple_pkg::CAPACITY_DEF;
    localparam int VALUE_W      = ple_pkg::VALUE_W;
    localparam int POS_W        = ple_pkg::POS_W;
    localparam int RANDOM_OPS   = 2000;
    localparam int CYCLE_LIMIT  = 1000000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;
    int   list_len;
    int   calm_left;

    ple_req_if req ();
    ple_rsp_if rsp ();

    positional_list_engine_core #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    ple_list_checker #(
        .CAPACITY (CAPACITY)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // mostly short gaps, a few long ones, and now and then a stretch with none
    function automatic int pick_gap();
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm_left = $urandom_range(40, 150);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // one request beat; also keeps a rough length so positions can be aimed
    task automatic send_op(input ple_pkg::op_t op, input int pos,
                           input logic [VALUE_W-1:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.operation <= op;
        req.position  <= POS_W'(pos);
        req.value     <= val;
        do @(posedge clk); while (!req.ready);
        pos = $signed(POS_W'(pos));
        if (op == ple_pkg::OP_INSERT && pos >= -1 && pos <= list_len && list_len < CAPACITY)
            list_len++;
        else if (op == ple_pkg::OP_DELETE && pos >= 1 && pos <= list_len)
            list_len--;
    endtask

    // response side: random stalls and runs of readiness
    initial
    begin
        int stall;
        rsp.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int            insert_pct;
        int            mode_left;
        int            pos;
        int            sel;
        ple_pkg::op_t  op;
        rst_n         <= 1'b0;
        req.valid     <= 1'b0;
        req.operation <= ple_pkg::OP_INSERT;
        req.position  <= '0;
        req.value     <= '0;
        list_len  = 0;
        calm_left = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list corners
        send_op(ple_pkg::OP_DELETE, 1, 32'h1234_5678);
        send_op(ple_pkg::OP_DELETE, 0, 32'h0);
        send_op(ple_pkg::OP_DELETE, -32, 32'hFFFF_FFFF);
        send_op(ple_pkg::OP_INSERT, -2, 32'h5555_5555);
        send_op(ple_pkg::OP_INSERT, 31, 32'hAAAA_AAAA);
        // append, front, middle
        send_op(ple_pkg::OP_INSERT, -1, 32'h7FFF_FFFF);
        send_op(ple_pkg::OP_INSERT, 0, 32'h8000_0000);
        send_op(ple_pkg::OP_INSERT, 1, 32'h0000_0001);
        while (list_len < CAPACITY)
            send_op(ple_pkg::OP_INSERT, -1, $urandom);
        // full list: range check wins over the full check
        send_op(ple_pkg::OP_INSERT, -1, 32'hDEAD_BEEF);
        send_op(ple_pkg::OP_INSERT, CAPACITY + 1, 32'hDEAD_BEEF);
        send_op(ple_pkg::OP_DELETE, CAPACITY, 32'h0);
        send_op(ple_pkg::OP_DELETE, 1, 32'h0);

        insert_pct = 80;
        mode_left  = $urandom_range(30, 80);
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (mode_left == 0)
            begin
                insert_pct = (insert_pct > 50) ? 25 : 80;
                mode_left  = $urandom_range(30, 80);
            end
            mode_left--;
            sel = $urandom_range(0, 99);
            if (sel < 7)
            begin
                // noise over the whole position field
                op  = ple_pkg::op_t'($urandom_range(0, 1));
                pos = $signed(POS_W'($urandom));
            end
            else if (sel < 12)
            begin
                // just outside the legal range
                op  = ple_pkg::op_t'($urandom_range(0, 1));
                pos = $urandom_range(0, 1) ? list_len + 1
                                           : ((op == ple_pkg::OP_INSERT) ? -2 : 0);
            end
            else
            begin
                op = ($urandom_range(0, 99) < insert_pct) ? ple_pkg::OP_INSERT
                                                          : ple_pkg::OP_DELETE;
                if (op == ple_pkg::OP_INSERT)
                    pos = ($urandom_range(0, 6) == 0) ? -1 : $urandom_range(0, list_len);
                else
                    pos = (list_len > 0) ? $urandom_range(1, list_len) : 1;
            end
            send_op(op, pos, pick_value());
        end
        req.valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (5) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
